FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: sv/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Constants, reaction tables and command codes of the reaction step block.
// ----------------------------------------------------------------------------
package srs_pkg;
	localparam int NUM_SPECIES   = 20;
	localparam int NUM_REACTIONS = 18;
	localparam int COUNT_BITS    = 16;
	localparam int FRACTION_BITS = 16;
	localparam int CMD_W   = 2;
	localparam int IDX_W   = 5;
	localparam int VAL_W   = 16;
	localparam int FRAC_W  = 16;
	localparam int RXN_W   = 5;
	localparam int TOTAL_W = 37;

	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_STEP = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [IDX_W-1:0]  species_index;
		logic [VAL_W-1:0]  count_value;
		logic [FRAC_W-1:0] random_fraction;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0]   count_readback;
		logic [RXN_W-1:0]   reaction_index;
		logic               no_reaction;
		logic [TOTAL_W-1:0] total_propensity;
	} rsp_t;

	function automatic logic [IDX_W-1:0] first_reactant(input logic [RXN_W-1:0] k);
		logic [IDX_W-1:0] r;
		case (k)
			5'd0: r = 5'd0;   5'd1: r = 5'd0;   5'd2: r = 5'd2;   5'd3: r = 5'd4;
			5'd4: r = 5'd3;   5'd5: r = 5'd3;   5'd6: r = 5'd1;   5'd7: r = 5'd5;
			5'd8: r = 5'd5;   5'd9: r = 5'd12;  5'd10: r = 5'd7;  5'd11: r = 5'd13;
			5'd12: r = 5'd8;  5'd13: r = 5'd10; 5'd14: r = 5'd2;  5'd15: r = 5'd0;
			5'd16: r = 5'd15; 5'd17: r = 5'd11;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] second_reactant(input logic [RXN_W-1:0] k);
		logic [IDX_W-1:0] r;
		case (k)
			5'd0: r = 5'd1;   5'd1: r = 5'd2;   5'd2: r = 5'd3;   5'd3: r = 5'd5;
			5'd4: r = 5'd6;   5'd5: r = 5'd6;   5'd6: r = 5'd5;   5'd7: r = 5'd6;
			5'd8: r = 5'd8;   5'd9: r = 5'd13;  5'd10: r = 5'd8;  5'd11: r = 5'd9;
			5'd12: r = 5'd9;  5'd13: r = 5'd9;  5'd14: r = 5'd12; 5'd15: r = 5'd15;
			5'd16: r = 5'd14; 5'd17: r = 5'd14;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	function automatic logic [IDX_W-1:0] product_species(input logic [RXN_W-1:0] k);
		logic [IDX_W-1:0] r;
		case (k)
			5'd0: r = 5'd2;   5'd1: r = 5'd3;   5'd2: r = 5'd4;   5'd3: r = 5'd6;
			5'd4: r = 5'd7;   5'd5: r = 5'd10;  5'd6: r = 5'd12;  5'd7: r = 5'd9;
			5'd8: r = 5'd13;  5'd9: r = 5'd15;  5'd10: r = 5'd9;  5'd11: r = 5'd14;
			5'd12: r = 5'd11; 5'd13: r = 5'd19; 5'd14: r = 5'd18; 5'd15: r = 5'd16;
			5'd16: r = 5'd17; 5'd17: r = 5'd18;
			default: r = 5'd0;
		endcase
		return r;
	endfunction
endpackage

FILE: sv/srs_if.sv
// ----------------------------------------------------------------------------
// srs_if
// Valid/ready channel carrying one packed payload.
// ----------------------------------------------------------------------------
interface srs_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: sv/srs_mac.sv
// ----------------------------------------------------------------------------
// srs_mac
// Shared multiply-accumulate unit: one propensity product per request,
// registered, then added to a running sum.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module srs_mac #(
	parameter int CountBits = srs_pkg::COUNT_BITS,
	parameter int SumBits   = 2*srs_pkg::COUNT_BITS + 5
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   clear,
	input  logic                   mul_en,
	input  logic                   acc_en,
	input  logic [CountBits-1:0]   a,
	input  logic [CountBits-1:0]   b,
	output logic [SumBits-1:0]     sum
);
	logic [2*CountBits-1:0] prod_q;
	logic [SumBits-1:0]     sum_q;

	always_ff @(posedge clk) begin
		if (mul_en) begin
			prod_q <= a * b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
		end else if (clear) begin
			sum_q <= '0;
		end else if (acc_en) begin
			sum_q <= sum_q + SumBits'(prod_q);
		end
	end

	assign sum = sum_q;

	`ASSERT_NEVER(a_clear_acc, clk, arst_n, clear && acc_en)
	`ASSERT_IMPL(a_clear_zero, clk, arst_n, clear |=> (sum_q == '0))
endmodule

FILE: sv/stochastic_reaction_step_top.sv
// ----------------------------------------------------------------------------
// stochastic_reaction_step_top
// Gillespie direct-method step over 20 species and 18 two-reactant reactions.
// ----------------------------------------------------------------------------
// channel | dir | payload
// req     | in  | cmd, species_index, count_value, random_fraction
// rsp     | out | count_readback, reaction_index, no_reaction, total_propensity
//
// A load or read request moves the sequencer to ST_OUT, which registers the result and sets its valid flag.
// A step sums the 18 products of the total in ST_SUM, latches it in ST_TGTW,
// forms the target multiply in ST_TGT, scans with a cumulative compare in
// ST_SCAN, makes three count updates and loads the result in ST_OUT; a zero
// total goes from ST_TGTW straight to ST_OUT. The multiplier is shared.
// Reset clears all counts at once (flip-flop store) and idles the sequencer.
// A stalled result holds; no request is taken until it is delivered.
`include "assert_macros.svh"
module stochastic_reaction_step_top #(
	parameter int CountBits    = srs_pkg::COUNT_BITS,
	parameter int FractionBits = srs_pkg::FRACTION_BITS
) (
	input logic clk,
	input logic arst_n,
	srs_if.sink   req,
	srs_if.source rsp
);
	import srs_pkg::*;

	localparam int SumBits = 2*CountBits + 5;
	localparam int CmpBits = SumBits + FractionBits;
	localparam logic [CountBits-1:0] CountMax = '1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SUM  = 4'd1;
	localparam logic [3:0] ST_TGT  = 4'd2;
	localparam logic [3:0] ST_SCAN = 4'd3;
	localparam logic [3:0] ST_DECA = 4'd4;
	localparam logic [3:0] ST_DECB = 4'd5;
	localparam logic [3:0] ST_INCP = 4'd6;
	localparam logic [3:0] ST_OUT  = 4'd7;
	localparam logic [3:0] ST_TGTW = 4'd8;

	logic [3:0]              state_q;
	logic [CountBits-1:0]    counts_q [NUM_SPECIES];
	req_t                    req_q;
	rsp_t                    rsp_q;
	logic                    rsp_valid_q;
	logic [RXN_W-1:0]        k_q;
	logic                    phase_q;   // 0: multiply issued, 1: accumulate
	logic [SumBits-1:0]      total_q;
	logic [CmpBits-1:0]      target_q;
	logic [RXN_W-1:0]        fired_q;

	logic                    mac_clear, mac_mul, mac_acc;
	logic [CountBits-1:0]    mac_a, mac_b;
	logic [SumBits-1:0]      mac_sum;
	logic [CmpBits-1:0]      cum_shift;
	logic                    idx_ok;
	logic [IDX_W-1:0]        sp_a, sp_b, sp_p;
	logic [CountBits-1:0]    cnt_a;

	srs_mac #(.CountBits(CountBits), .SumBits(SumBits)) u_mac (
		.clk(clk), .arst_n(arst_n), .clear(mac_clear), .mul_en(mac_mul),
		.acc_en(mac_acc), .a(mac_a), .b(mac_b), .sum(mac_sum)
	);

	assign sp_a   = first_reactant(fired_q);
	assign sp_b   = second_reactant(fired_q);
	assign sp_p   = product_species(fired_q);
	assign idx_ok = req_q.species_index < IDX_W'(NUM_SPECIES);
	assign cum_shift = {mac_sum, {FractionBits{1'b0}}};
	assign cnt_a  = counts_q[sp_a];

	always_comb begin
		mac_a = counts_q[first_reactant(k_q)];
		mac_b = counts_q[second_reactant(k_q)];
		mac_clear = 1'b0;
		mac_mul = 1'b0;
		mac_acc = 1'b0;
		case (state_q)
			ST_IDLE: mac_clear = 1'b1;
			ST_SUM, ST_SCAN: begin
				mac_mul = !phase_q;
				mac_acc = phase_q;
			end
			ST_TGT: begin
				// clear the running sum before the scan
				mac_clear = 1'b1;
			end
			default: ;
		endcase
	end

	assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	always_ff @(posedge clk) begin
		if (state_q == ST_TGT) begin
			target_q <= CmpBits'(total_q) *
				CmpBits'(FractionBits'(req_q.random_fraction));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
			k_q         <= '0;
			phase_q     <= 1'b0;
			fired_q     <= '0;
			total_q     <= '0;
			req_q       <= '0;
			rsp_q       <= '0;
			for (int i = 0; i < NUM_SPECIES; i++) begin
				counts_q[i] <= '0;
			end
		end else begin
			if (rsp.valid && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req.valid && req.ready) begin
						req_q   <= req.data;
						k_q     <= '0;
						phase_q <= 1'b0;
						rsp_q   <= '0;
						if (req.data.cmd == CMD_STEP) begin
							state_q <= ST_SUM;
						end else begin
							state_q <= ST_OUT;
						end
					end
				end
				ST_SUM: begin
					phase_q <= !phase_q;
					if (phase_q) begin
						if (k_q == RXN_W'(NUM_REACTIONS-1)) begin
							state_q <= ST_TGTW;
						end else begin
							k_q <= k_q + 1'b1;
						end
					end
				end
				ST_TGTW: begin
					total_q <= mac_sum;
					rsp_q.total_propensity <= TOTAL_W'(mac_sum);
					if (mac_sum == '0) begin
						rsp_q.no_reaction <= 1'b1;
						state_q <= ST_OUT;
					end else begin
						state_q <= ST_TGT;
					end
				end
				ST_TGT: begin
					k_q     <= '0;
					phase_q <= 1'b0;
					state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					phase_q <= !phase_q;
					if (!phase_q && k_q != '0) begin
						// compare after previous accumulate
						if (target_q < cum_shift) begin
							fired_q <= k_q - 1'b1;
							state_q <= ST_DECA;
						end
					end else if (phase_q && k_q == RXN_W'(NUM_REACTIONS-1)) begin
						k_q <= k_q + 1'b1;
					end else if (phase_q) begin
						k_q <= k_q + 1'b1;
					end
					if (!phase_q && k_q == RXN_W'(NUM_REACTIONS) && !(target_q < cum_shift)) begin
						rsp_q.no_reaction <= 1'b1;
						state_q <= ST_OUT;
					end
				end
				ST_DECA: begin
					rsp_q.reaction_index <= fired_q;
					if (cnt_a != '0) counts_q[sp_a] <= cnt_a - 1'b1;
					state_q <= ST_DECB;
				end
				ST_DECB: begin
					if (counts_q[sp_b] != '0) counts_q[sp_b] <= counts_q[sp_b] - 1'b1;
					state_q <= ST_INCP;
				end
				ST_INCP: begin
					if (counts_q[sp_p] != CountMax) counts_q[sp_p] <= counts_q[sp_p] + 1'b1;
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (req_q.cmd == CMD_LOAD || req_q.cmd == CMD_READ) begin
						if (idx_ok) begin
							if (req_q.cmd == CMD_LOAD) begin
								counts_q[req_q.species_index] <= CountBits'(req_q.count_value);
							end
							rsp_q.count_readback <= VAL_W'((req_q.cmd == CMD_LOAD) ?
								CountBits'(req_q.count_value) : counts_q[req_q.species_index]);
						end
					end
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`ASSERT_IMPL(a_busy_not_ready, clk, arst_n, (state_q != ST_IDLE) |-> !req.ready)
	`ASSERT_IMPL(a_out_valid, clk, arst_n, (state_q == ST_OUT) |=> rsp_valid_q)
	`ASSERT_NEVER(a_fired_range, clk, arst_n,
		(state_q == ST_DECA) && (fired_q >= RXN_W'(NUM_REACTIONS)))
endmodule
